### hdl/gcd_pkg.sv
package gcd_pkg;

	localparam int CORDIC_STAGES = 24;
	localparam int LANES = 4;
	localparam int Q = 30;

	localparam int LAT_W = 31;
	localparam int LON_W = 32;
	localparam int RAD_W = 16;
	localparam int DIST_W = 34;
	localparam int IN_W = 128;
	localparam int OUT_W = 40;

	localparam int ANG_W = 33;
	localparam int MOD_W = 33;
	localparam int R_W = 31;
	localparam int PROD_W = 63;
	localparam int XY_W = 34;
	localparam int Z_W = 33;
	localparam int SQ_W = 62;
	localparam int SQ_STEPS = 31;
	localparam int ROOT_W = 31;
	localparam int C_W = 33;
	localparam int DP_W = C_W + RAD_W;
	localparam int D_RND = 13;
	localparam int D_SHIFT = 14;

	localparam logic signed [ANG_W:0] FULL_TURN_S = 34'sd7200000000;
	localparam logic [MOD_W-1:0] QUARTER_TURN = 33'd1800000000;
	localparam logic [MOD_W-1:0] HALF_TURN = 33'd3600000000;
	localparam logic [MOD_W-1:0] THREE_QUARTER = 33'd5400000000;
	localparam logic [31:0] RAD_SCALE = 32'd4024455255;
	localparam logic [ROOT_W-1:0] ONE_A = 31'd1073741824;
	localparam logic [RAD_W-1:0] RADIUS_RST = 16'd6371;
	localparam logic [DIST_W-1:0] DIST_MAX = '1;

	typedef logic signed [ANG_W-1:0] turn_t;
	typedef logic signed [XY_W-1:0] xy_t;
	typedef logic signed [Z_W-1:0] ang_t;

	typedef enum logic [1:0] {
		QUAD_0,
		QUAD_1,
		QUAD_2,
		QUAD_3
	} quad_t;

	typedef struct packed {
		xy_t cos_v;
		xy_t sin_v;
	} trig_t;

	localparam xy_t INV_GAIN = 34'sd652032874;

	function automatic ang_t atan_q30(input int i);
		ang_t t;
		unique case (i)
			0: t = 33'sd843314856;
			1: t = 33'sd497837829;
			2: t = 33'sd263043836;
			3: t = 33'sd133525158;
			4: t = 33'sd67021686;
			5: t = 33'sd33543515;
			6: t = 33'sd16775850;
			7: t = 33'sd8388437;
			8: t = 33'sd4194282;
			9: t = 33'sd2097149;
			default: begin
				if (i <= 30) begin
					t = ang_t'(64'sd1 <<< (30 - i));
				end else begin
					t = '0;
				end
			end
		endcase
		return t;
	endfunction

endpackage

### hdl/gcd_sincos.sv
module gcd_sincos import gcd_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic signed [LAT_W-1:0] first_lat,
	input  logic signed [LAT_W-1:0] second_lat,
	input  logic signed [LON_W-1:0] first_lon,
	input  logic signed [LON_W-1:0] second_lon,
	output logic                    out_valid,
	input  logic                    out_ready,
	output trig_t                   trig [LANES]
);

	localparam int PRE = 5;
	localparam int NST = PRE + CORDIC_STAGES + 1;

	logic [NST-1:0] vld_q;
	logic [NST-1:0] vin;
	logic [NST:0]   en;

	turn_t            ang_s1 [LANES];
	logic [MOD_W-1:0] mod_s2 [LANES];
	quad_t            q_s3 [LANES];
	logic [R_W-1:0]   r_s3 [LANES];
	quad_t            q_s4 [LANES];
	logic [PROD_W-1:0] prod_s4 [LANES];
	quad_t            q_s5 [LANES];
	ang_t             z_s5 [LANES];

	xy_t   cx_s [CORDIC_STAGES][LANES];
	xy_t   cy_s [CORDIC_STAGES][LANES];
	ang_t  cz_s [CORDIC_STAGES][LANES];
	quad_t cq_s [CORDIC_STAGES][LANES];

	xy_t   cin_x [CORDIC_STAGES][LANES];
	xy_t   cin_y [CORDIC_STAGES][LANES];
	ang_t  cin_z [CORDIC_STAGES][LANES];
	quad_t cin_q [CORDIC_STAGES][LANES];
	xy_t   cnx [CORDIC_STAGES][LANES];
	xy_t   cny [CORDIC_STAGES][LANES];
	ang_t  cnz [CORDIC_STAGES][LANES];

	trig_t trig_s [LANES];

	logic signed [ANG_W:0] wide [LANES];
	logic [PROD_W:0]       rnd [LANES];

	assign en[NST] = out_ready;
	assign vin = {vld_q[NST-2:0], in_valid};

	genvar g;
	generate
		for (g = 0; g < NST; g++) begin : g_en
			assign en[g] = !vld_q[g] || en[g+1];
		end
	endgenerate

	assign in_ready = en[0];
	assign out_valid = vld_q[NST-1];
	assign trig = trig_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int k = 0; k < NST; k++) begin
				if (en[k]) begin
					vld_q[k] <= vin[k];
				end
			end
		end
	end

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			wide[l] = (ANG_W+1)'(ang_s1[l]) + (ang_s1[l][ANG_W-1] ? FULL_TURN_S : '0);
			rnd[l] = (PROD_W+1)'(prod_s4[l]) + ((PROD_W+1)'(1) << 31);
		end
		for (int l = 0; l < LANES; l++) begin
			cin_x[0][l] = INV_GAIN;
			cin_y[0][l] = '0;
			cin_z[0][l] = z_s5[l];
			cin_q[0][l] = q_s5[l];
		end
		for (int k = 1; k < CORDIC_STAGES; k++) begin
			for (int l = 0; l < LANES; l++) begin
				cin_x[k][l] = cx_s[k-1][l];
				cin_y[k][l] = cy_s[k-1][l];
				cin_z[k][l] = cz_s[k-1][l];
				cin_q[k][l] = cq_s[k-1][l];
			end
		end
		for (int k = 0; k < CORDIC_STAGES; k++) begin
			for (int l = 0; l < LANES; l++) begin
				if (!cin_z[k][l][Z_W-1]) begin
					cnx[k][l] = cin_x[k][l] - (cin_y[k][l] >>> k);
					cny[k][l] = cin_y[k][l] + (cin_x[k][l] >>> k);
					cnz[k][l] = cin_z[k][l] - atan_q30(k);
				end else begin
					cnx[k][l] = cin_x[k][l] + (cin_y[k][l] >>> k);
					cny[k][l] = cin_y[k][l] - (cin_x[k][l] >>> k);
					cnz[k][l] = cin_z[k][l] + atan_q30(k);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			ang_s1[0] <= ANG_W'(first_lat) <<< 1;
			ang_s1[1] <= ANG_W'(second_lat) <<< 1;
			ang_s1[2] <= ANG_W'(second_lat) - ANG_W'(first_lat);
			ang_s1[3] <= ANG_W'(second_lon) - ANG_W'(first_lon);
		end
		if (en[1]) begin
			for (int l = 0; l < LANES; l++) begin
				mod_s2[l] <= MOD_W'(wide[l]);
			end
		end
		if (en[2]) begin
			for (int l = 0; l < LANES; l++) begin
				priority if (mod_s2[l] >= THREE_QUARTER) begin
					q_s3[l] <= QUAD_3;
					r_s3[l] <= R_W'(mod_s2[l] - THREE_QUARTER);
				end else if (mod_s2[l] >= HALF_TURN) begin
					q_s3[l] <= QUAD_2;
					r_s3[l] <= R_W'(mod_s2[l] - HALF_TURN);
				end else if (mod_s2[l] >= QUARTER_TURN) begin
					q_s3[l] <= QUAD_1;
					r_s3[l] <= R_W'(mod_s2[l] - QUARTER_TURN);
				end else begin
					q_s3[l] <= QUAD_0;
					r_s3[l] <= R_W'(mod_s2[l]);
				end
			end
		end
		if (en[3]) begin
			for (int l = 0; l < LANES; l++) begin
				q_s4[l] <= q_s3[l];
				prod_s4[l] <= PROD_W'(r_s3[l]) * PROD_W'(RAD_SCALE);
			end
		end
		if (en[4]) begin
			for (int l = 0; l < LANES; l++) begin
				q_s5[l] <= q_s4[l];
				z_s5[l] <= ang_t'({2'b00, rnd[l][PROD_W-1:32]});
			end
		end
		for (int k = 0; k < CORDIC_STAGES; k++) begin
			if (en[PRE+k]) begin
				for (int l = 0; l < LANES; l++) begin
					cx_s[k][l] <= cnx[k][l];
					cy_s[k][l] <= cny[k][l];
					cz_s[k][l] <= cnz[k][l];
					cq_s[k][l] <= cin_q[k][l];
				end
			end
		end
		if (en[NST-1]) begin
			for (int l = 0; l < LANES; l++) begin
				unique case (cq_s[CORDIC_STAGES-1][l])
					QUAD_0: begin
						trig_s[l].cos_v <= cx_s[CORDIC_STAGES-1][l];
						trig_s[l].sin_v <= cy_s[CORDIC_STAGES-1][l];
					end
					QUAD_1: begin
						trig_s[l].cos_v <= -cy_s[CORDIC_STAGES-1][l];
						trig_s[l].sin_v <= cx_s[CORDIC_STAGES-1][l];
					end
					QUAD_2: begin
						trig_s[l].cos_v <= -cx_s[CORDIC_STAGES-1][l];
						trig_s[l].sin_v <= -cy_s[CORDIC_STAGES-1][l];
					end
					default: begin
						trig_s[l].cos_v <= cy_s[CORDIC_STAGES-1][l];
						trig_s[l].sin_v <= -cx_s[CORDIC_STAGES-1][l];
					end
				endcase
			end
		end
	end

endmodule

### hdl/gcd_haver.sv
module gcd_haver import gcd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  trig_t             trig [LANES],
	output logic              out_valid,
	input  logic              out_ready,
	output logic [ROOT_W-1:0] sa,
	output logic [ROOT_W-1:0] sb
);

	localparam int PRE = 3;
	localparam int NST = PRE + SQ_STEPS;
	localparam logic signed [XY_W:0] ONE_S = 35'sd1073741824;

	logic [NST-1:0] vld_q;
	logic [NST-1:0] vin;
	logic [NST:0]   en;

	xy_t sqlat_s1, sqlon_s1, cc_s1;
	xy_t sqlat_s2, t_s2;
	logic [ROOT_W-1:0] a_s3;

	logic [SQ_W-1:0] na_s [SQ_STEPS];
	logic [SQ_W-1:0] ra_s [SQ_STEPS];
	logic [SQ_W-1:0] nb_s [SQ_STEPS];
	logic [SQ_W-1:0] rb_s [SQ_STEPS];

	logic [SQ_W-1:0] na_i [SQ_STEPS];
	logic [SQ_W-1:0] ra_i [SQ_STEPS];
	logic [SQ_W-1:0] nb_i [SQ_STEPS];
	logic [SQ_W-1:0] rb_i [SQ_STEPS];
	logic [SQ_W-1:0] na_n [SQ_STEPS];
	logic [SQ_W-1:0] ra_n [SQ_STEPS];
	logic [SQ_W-1:0] nb_n [SQ_STEPS];
	logic [SQ_W-1:0] rb_n [SQ_STEPS];
	logic [SQ_W-1:0] bit_v [SQ_STEPS];
	logic [SQ_W-1:0] ta [SQ_STEPS];
	logic [SQ_W-1:0] tb [SQ_STEPS];

	logic signed [2*XY_W-1:0] p_lat, p_lon, p_cc, p_t;
	logic signed [XY_W:0]     a_sum;

	assign en[NST] = out_ready;
	assign vin = {vld_q[NST-2:0], in_valid};

	genvar g;
	generate
		for (g = 0; g < NST; g++) begin : g_en
			assign en[g] = !vld_q[g] || en[g+1];
		end
	endgenerate

	assign in_ready = en[0];
	assign out_valid = vld_q[NST-1];
	assign sa = ROOT_W'(ra_s[SQ_STEPS-1]);
	assign sb = ROOT_W'(rb_s[SQ_STEPS-1]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int k = 0; k < NST; k++) begin
				if (en[k]) begin
					vld_q[k] <= vin[k];
				end
			end
		end
	end

	always_comb begin
		p_lat = trig[2].sin_v * trig[2].sin_v;
		p_lon = trig[3].sin_v * trig[3].sin_v;
		p_cc = trig[0].cos_v * trig[1].cos_v;
		p_t = cc_s1 * sqlon_s1;
		a_sum = (XY_W+1)'(sqlat_s2) + (XY_W+1)'(t_s2);
		na_i[0] = SQ_W'(a_s3) << Q;
		nb_i[0] = SQ_W'(ONE_A - a_s3) << Q;
		ra_i[0] = '0;
		rb_i[0] = '0;
		for (int j = 1; j < SQ_STEPS; j++) begin
			na_i[j] = na_s[j-1];
			ra_i[j] = ra_s[j-1];
			nb_i[j] = nb_s[j-1];
			rb_i[j] = rb_s[j-1];
		end
		for (int j = 0; j < SQ_STEPS; j++) begin
			bit_v[j] = SQ_W'(1) << (2 * (SQ_STEPS - 1 - j));
			ta[j] = ra_i[j] + bit_v[j];
			tb[j] = rb_i[j] + bit_v[j];
			if (na_i[j] >= ta[j]) begin
				na_n[j] = na_i[j] - ta[j];
				ra_n[j] = (ra_i[j] >> 1) + bit_v[j];
			end else begin
				na_n[j] = na_i[j];
				ra_n[j] = ra_i[j] >> 1;
			end
			if (nb_i[j] >= tb[j]) begin
				nb_n[j] = nb_i[j] - tb[j];
				rb_n[j] = (rb_i[j] >> 1) + bit_v[j];
			end else begin
				nb_n[j] = nb_i[j];
				rb_n[j] = rb_i[j] >> 1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			sqlat_s1 <= xy_t'(p_lat >>> Q);
			sqlon_s1 <= xy_t'(p_lon >>> Q);
			cc_s1 <= xy_t'(p_cc >>> Q);
		end
		if (en[1]) begin
			sqlat_s2 <= sqlat_s1;
			t_s2 <= xy_t'(p_t >>> Q);
		end
		if (en[2]) begin
			priority if (a_sum < 0) begin
				a_s3 <= '0;
			end else if (a_sum > ONE_S) begin
				a_s3 <= ONE_A;
			end else begin
				a_s3 <= ROOT_W'(a_sum);
			end
		end
		for (int j = 0; j < SQ_STEPS; j++) begin
			if (en[PRE+j]) begin
				na_s[j] <= na_n[j];
				ra_s[j] <= ra_n[j];
				nb_s[j] <= nb_n[j];
				rb_s[j] <= rb_n[j];
			end
		end
	end

	a_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[2] |-> a_s3 <= ONE_A)
		else $error("haversine term out of unit range");

	a_root_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (sa <= ONE_A) && (sb <= ONE_A))
		else $error("square root out of range");

endmodule

### hdl/gcd_vector.sv
module gcd_vector import gcd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [ROOT_W-1:0] sa,
	input  logic [ROOT_W-1:0] sb,
	input  logic [RAD_W-1:0]  radius,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [DIST_W-1:0] distance
);

	localparam int NST = CORDIC_STAGES + 3;
	localparam int RW = DP_W + 1;

	logic [NST-1:0] vld_q;
	logic [NST-1:0] vin;
	logic [NST:0]   en;

	xy_t  vx_s [CORDIC_STAGES];
	xy_t  vy_s [CORDIC_STAGES];
	ang_t vz_s [CORDIC_STAGES];
	xy_t  vin_x [CORDIC_STAGES];
	xy_t  vin_y [CORDIC_STAGES];
	ang_t vin_z [CORDIC_STAGES];
	xy_t  vnx [CORDIC_STAGES];
	xy_t  vny [CORDIC_STAGES];
	ang_t vnz [CORDIC_STAGES];

	logic [C_W-1:0]    c_s1;
	logic [DP_W-1:0]   prod_s2;
	logic [DIST_W-1:0] dist_s3;

	logic signed [Z_W:0] c2;
	logic [RW-1:0]       rnd;
	logic [RW-1:0]       shifted;

	assign en[NST] = out_ready;
	assign vin = {vld_q[NST-2:0], in_valid};

	genvar g;
	generate
		for (g = 0; g < NST; g++) begin : g_en
			assign en[g] = !vld_q[g] || en[g+1];
		end
	endgenerate

	assign in_ready = en[0];
	assign out_valid = vld_q[NST-1];
	assign distance = dist_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int k = 0; k < NST; k++) begin
				if (en[k]) begin
					vld_q[k] <= vin[k];
				end
			end
		end
	end

	always_comb begin
		vin_x[0] = xy_t'({{(XY_W-ROOT_W){1'b0}}, sb});
		vin_y[0] = xy_t'({{(XY_W-ROOT_W){1'b0}}, sa});
		vin_z[0] = '0;
		for (int k = 1; k < CORDIC_STAGES; k++) begin
			vin_x[k] = vx_s[k-1];
			vin_y[k] = vy_s[k-1];
			vin_z[k] = vz_s[k-1];
		end
		for (int k = 0; k < CORDIC_STAGES; k++) begin
			if (vin_y[k] > 0) begin
				vnx[k] = vin_x[k] + (vin_y[k] >>> k);
				vny[k] = vin_y[k] - (vin_x[k] >>> k);
				vnz[k] = vin_z[k] + atan_q30(k);
			end else begin
				vnx[k] = vin_x[k] - (vin_y[k] >>> k);
				vny[k] = vin_y[k] + (vin_x[k] >>> k);
				vnz[k] = vin_z[k] - atan_q30(k);
			end
		end
		c2 = (Z_W+1)'(vz_s[CORDIC_STAGES-1]) <<< 1;
		rnd = RW'(prod_s2) + (RW'(1) << D_RND);
		shifted = rnd >> D_SHIFT;
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < CORDIC_STAGES; k++) begin
			if (en[k]) begin
				vx_s[k] <= vnx[k];
				vy_s[k] <= vny[k];
				vz_s[k] <= vnz[k];
			end
		end
		if (en[CORDIC_STAGES]) begin
			c_s1 <= c2[Z_W] ? '0 : C_W'(c2);
		end
		if (en[CORDIC_STAGES+1]) begin
			prod_s2 <= DP_W'(c_s1) * DP_W'(radius);
		end
		if (en[CORDIC_STAGES+2]) begin
			dist_s3 <= (shifted > RW'(DIST_MAX)) ? DIST_MAX : DIST_W'(shifted);
		end
	end

	a_zero_radius: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[CORDIC_STAGES+1] && en[CORDIC_STAGES+2] && (prod_s2 == '0)
		|=> dist_s3 == '0)
		else $error("zero product gave nonzero distance");

endmodule

### hdl/great_circle_distance.sv
// Great-circle distance between two points, haversine form, fixed point.
// Input stream s_*: one request per item carrying both points as latitude
// and longitude in 1e-7 degree units. Output stream m_*: one distance per
// request, km as unsigned Q16, in request order.
// radius_km_we / radius_km load the sphere radius in whole km (reset 6371);
// write only while no request is in flight.
// Pipeline: sine/cosine (range reduction and rotation CORDIC), then products
// and two bit-per-stage square roots, then vectoring CORDIC and scaling.
// Throughput: one request per cycle while m_tready is high; every stage holds one request.
// Each stage has its own valid bit and advances when it is empty or its
// successor advances, so bubbles close up while m_tready is low and s_tready
// drops only once every stage holds a request.
// Reset clears all valid bits and restores the radius; payload is not reset.
module great_circle_distance import gcd_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	// first_lat[30:0], second_lat[61:31], first_lon[93:62], second_lon[125:94]
	input  logic [IN_W-1:0]    s_tdata,
	output logic               m_tvalid,
	input  logic               m_tready,
	// distance[33:0]
	output logic [OUT_W-1:0]   m_tdata,
	input  logic               radius_km_we,
	input  logic [RAD_W-1:0]   radius_km
);

	logic [RAD_W-1:0] radius_q;

	logic  sc_valid, sc_ready;
	trig_t trig [LANES];
	logic  hv_valid, hv_ready;
	logic [ROOT_W-1:0] sa, sb;
	logic [DIST_W-1:0] distance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= RADIUS_RST;
		end else if (radius_km_we) begin
			radius_q <= radius_km;
		end
	end

	gcd_sincos u_sincos (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.first_lat  (s_tdata[LAT_W-1:0]),
		.second_lat (s_tdata[2*LAT_W-1:LAT_W]),
		.first_lon  (s_tdata[2*LAT_W+LON_W-1:2*LAT_W]),
		.second_lon (s_tdata[2*LAT_W+2*LON_W-1:2*LAT_W+LON_W]),
		.out_valid  (sc_valid),
		.out_ready  (sc_ready),
		.trig       (trig)
	);

	gcd_haver u_haver (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sc_valid),
		.in_ready  (sc_ready),
		.trig      (trig),
		.out_valid (hv_valid),
		.out_ready (hv_ready),
		.sa        (sa),
		.sb        (sb)
	);

	gcd_vector u_vector (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (hv_valid),
		.in_ready  (hv_ready),
		.sa        (sa),
		.sb        (sb),
		.radius    (radius_q),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.distance  (distance)
	);

	assign m_tdata = {{(OUT_W-DIST_W){1'b0}}, distance};

	a_stall_origin: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input stalled without output backpressure");

	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		m_tready |-> s_tready)
		else $error("input not ready while output drains");

endmodule
